FILE: hw/rtl/assert_macros.svh
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every clock edge, held off while reset is high.
`define VP3_ASSERT(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error("vp3 assertion failed");

// Checks that a condition in one cycle gives an outcome in the next one.
`define VP3_ASSERT_NEXT(label, cond, outcome) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (outcome)) \
      else $error("vp3 assertion failed");

`endif

FILE: hw/rtl/vp3_pkg.sv
// Package of shared types for the vector projection unit.
package vp3_pkg;

   // Control bits that travel with each item down the pipeline.
   typedef struct packed {
      logic valid;  // The stage holds an item.
      logic zero;   // Vector b has zero length.
      logic neg;    // The dot product is negative.
   } vp3_ctl_type;

endpackage

FILE: hw/rtl/vector_projection_3d_unit.sv
// Top level of the pipelined 3D vector projection unit.
//
// The req_ channel takes an item of two signed vectors a and b; an item is
// accepted at an edge where req_valid is high and req_stall is low. The rsp_
// channel gives one item for each: the dot product a.b, the floor square
// root of |b|^2, the projection b * (a.b / |b|^2) with the quotient
// truncated toward zero, and a flag set when b is the zero vector, in which
// case the projection is zero.
// From acceptance to rsp_valid an item passes one stage of multipliers, one
// of sums, COMPONENT_BITS + 1 stages that each form one quotient bit (all but
// the last also one root bit), and one stage of output multipliers. One item
// is accepted in every cycle in which req_stall is low.
// Reset clears every valid bit, so the pipeline comes up empty.
// When the receiver stalls a waiting result, the whole pipeline holds and
// req_stall is raised in the same cycle; nothing is lost or repeated.
module vector_projection_3d_unit #(
   parameter int COMPONENT_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [COMPONENT_BITS-1:0] req_a_x,
   input  logic signed [COMPONENT_BITS-1:0] req_a_y,
   input  logic signed [COMPONENT_BITS-1:0] req_a_z,
   input  logic signed [COMPONENT_BITS-1:0] req_b_x,
   input  logic signed [COMPONENT_BITS-1:0] req_b_y,
   input  logic signed [COMPONENT_BITS-1:0] req_b_z,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [2*COMPONENT_BITS:0] rsp_dot_product,
   output logic [COMPONENT_BITS-1:0]     rsp_b_length,
   output logic signed [COMPONENT_BITS:0] rsp_proj_x,
   output logic signed [COMPONENT_BITS:0] rsp_proj_y,
   output logic signed [COMPONENT_BITS:0] rsp_proj_z,
   output logic                          rsp_zero_length
);

   localparam int N = COMPONENT_BITS;

   logic en;

   // First stage: products.
   logic                   s1_valid_ff;
   logic signed [2*N-1:0]  s1_px_ff, s1_py_ff, s1_pz_ff;
   logic signed [2*N-1:0]  s1_qx_ff, s1_qy_ff, s1_qz_ff;
   logic signed [N-1:0]    s1_bx_ff, s1_by_ff, s1_bz_ff;

   // Second stage: sums.
   vp3_pkg::vp3_ctl_type   s2_ctl_ff, s2_ctl_in;
   logic signed [2*N:0]    s2_dot_ff, s2_dot_in;
   logic [2*N-1:0]         s2_sq_ff, s2_sq_in;
   logic [2*N-1:0]         s2_mag_ff, s2_mag_in;
   logic signed [N-1:0]    s2_bx_ff, s2_by_ff, s2_bz_ff;
   logic signed [2*N:0]    neg_dot;

   // Links between the iteration stages.
   vp3_pkg::vp3_ctl_type   ctl_w  [0:N+1];
   logic signed [2*N:0]    dot_w  [0:N+1];
   logic [2*N-1:0]         sq_w   [0:N+1];
   logic [2*N-1:0]         mag_w  [0:N+1];
   logic [2*N-1:0]         rem_w  [0:N+1];
   logic [N:0]             quo_w  [0:N+1];
   logic [N-1:0]           root_w [0:N+1];
   logic [N+2:0]           srem_w [0:N+1];
   logic signed [N-1:0]    bx_w   [0:N+1];
   logic signed [N-1:0]    by_w   [0:N+1];
   logic signed [N-1:0]    bz_w   [0:N+1];

   // Output stage.
   logic                   out_valid_ff;
   logic signed [2*N:0]    out_dot_ff;
   logic [N-1:0]           out_len_ff;
   logic signed [N:0]      out_px_ff, out_py_ff, out_pz_ff, out_px_in, out_py_in, out_pz_in;
   logic                   out_zero_ff;
   logic signed [N+1:0]    quo_signed;
   logic signed [2*N+1:0]  prod_x, prod_y, prod_z;

   // The whole pipeline moves unless a finished item is held by the receiver.
   assign en        = !(out_valid_ff && rsp_stall);
   assign req_stall = out_valid_ff && rsp_stall;

   // Products for the dot product and for the squared length of b.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff <= req_valid;
      end
      if (en) begin
         s1_px_ff <= req_a_x * req_b_x;
         s1_py_ff <= req_a_y * req_b_y;
         s1_pz_ff <= req_a_z * req_b_z;
         s1_qx_ff <= req_b_x * req_b_x;
         s1_qy_ff <= req_b_y * req_b_y;
         s1_qz_ff <= req_b_z * req_b_z;
         s1_bx_ff <= req_b_x;
         s1_by_ff <= req_b_y;
         s1_bz_ff <= req_b_z;
      end
   end

   // Sums, the sign of the quotient and the dividend magnitude.
   always_comb begin
      s2_dot_in = (2*N+1)'(s1_px_ff) + (2*N+1)'(s1_py_ff) + (2*N+1)'(s1_pz_ff);
      s2_sq_in  = s1_qx_ff + s1_qy_ff + s1_qz_ff;
      neg_dot   = -s2_dot_in;
      s2_mag_in = s2_dot_in[2*N] ? neg_dot[2*N-1:0] : s2_dot_in[2*N-1:0];
      s2_ctl_in.valid = s1_valid_ff;
      s2_ctl_in.zero  = (s2_sq_in == '0);
      s2_ctl_in.neg   = s2_dot_in[2*N];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_ctl_ff.valid <= 1'b0;
      end else if (en) begin
         s2_ctl_ff.valid <= s2_ctl_in.valid;
      end
      if (en) begin
         s2_ctl_ff.zero <= s2_ctl_in.zero;
         s2_ctl_ff.neg  <= s2_ctl_in.neg;
         s2_dot_ff      <= s2_dot_in;
         s2_sq_ff       <= s2_sq_in;
         s2_mag_ff      <= s2_mag_in;
         s2_bx_ff       <= s1_bx_ff;
         s2_by_ff       <= s1_by_ff;
         s2_bz_ff       <= s1_bz_ff;
      end
   end

   // The quotient is below 2^(N+1), so the division starts with the top bits
   // of the dividend already in the partial remainder.
   assign ctl_w[0]  = s2_ctl_ff;
   assign dot_w[0]  = s2_dot_ff;
   assign sq_w[0]   = s2_sq_ff;
   assign mag_w[0]  = s2_mag_ff;
   assign rem_w[0]  = {{(N+1){1'b0}}, s2_mag_ff[2*N-1:N+1]};
   assign quo_w[0]  = '0;
   assign root_w[0] = '0;
   assign srem_w[0] = '0;
   assign bx_w[0]   = s2_bx_ff;
   assign by_w[0]   = s2_by_ff;
   assign bz_w[0]   = s2_bz_ff;

   // Iteration stages for the quotient and the square root.
   generate
      for (genvar k = 0; k <= N; k++) begin : g_stage
         vp3_stage #(.N(N), .STEP(k)) u_stage (
            .clock  (clock),
            .reset  (reset),
            .en     (en),
            .ctl_i  (ctl_w[k]),
            .dot_i  (dot_w[k]),
            .sq_i   (sq_w[k]),
            .mag_i  (mag_w[k]),
            .rem_i  (rem_w[k]),
            .quo_i  (quo_w[k]),
            .root_i (root_w[k]),
            .srem_i (srem_w[k]),
            .bx_i   (bx_w[k]),
            .by_i   (by_w[k]),
            .bz_i   (bz_w[k]),
            .ctl_o  (ctl_w[k+1]),
            .dot_o  (dot_w[k+1]),
            .sq_o   (sq_w[k+1]),
            .mag_o  (mag_w[k+1]),
            .rem_o  (rem_w[k+1]),
            .quo_o  (quo_w[k+1]),
            .root_o (root_w[k+1]),
            .srem_o (srem_w[k+1]),
            .bx_o   (bx_w[k+1]),
            .by_o   (by_w[k+1]),
            .bz_o   (bz_w[k+1])
         );
      end
   endgenerate

   // Signed quotient times b; a zero-length b forces a zero projection.
   always_comb begin
      quo_signed = ctl_w[N+1].neg ? -$signed({1'b0, quo_w[N+1]}) : $signed({1'b0, quo_w[N+1]});
      prod_x     = bx_w[N+1] * quo_signed;
      prod_y     = by_w[N+1] * quo_signed;
      prod_z     = bz_w[N+1] * quo_signed;
      out_px_in  = ctl_w[N+1].zero ? '0 : prod_x[N:0];
      out_py_in  = ctl_w[N+1].zero ? '0 : prod_y[N:0];
      out_pz_in  = ctl_w[N+1].zero ? '0 : prod_z[N:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (en) begin
         out_valid_ff <= ctl_w[N+1].valid;
      end
      if (en) begin
         out_dot_ff  <= dot_w[N+1];
         out_len_ff  <= root_w[N+1];
         out_px_ff   <= out_px_in;
         out_py_ff   <= out_py_in;
         out_pz_ff   <= out_pz_in;
         out_zero_ff <= ctl_w[N+1].zero;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_dot_product = out_dot_ff;
   assign rsp_b_length    = out_len_ff;
   assign rsp_proj_x      = out_px_ff;
   assign rsp_proj_y      = out_py_ff;
   assign rsp_proj_z      = out_pz_ff;
   assign rsp_zero_length = out_zero_ff;

endmodule

FILE: hw/rtl/vp3_stage.sv
// One pipeline stage: one quotient bit of the division and, in all but the last stage, one bit of the square root.
module vp3_stage #(
   parameter int N    = 16,
   parameter int STEP = 0
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   en,
   input  vp3_pkg::vp3_ctl_type   ctl_i,
   input  logic signed [2*N:0]    dot_i,
   input  logic [2*N-1:0]         sq_i,
   input  logic [2*N-1:0]         mag_i,
   input  logic [2*N-1:0]         rem_i,
   input  logic [N:0]             quo_i,
   input  logic [N-1:0]           root_i,
   input  logic [N+2:0]           srem_i,
   input  logic signed [N-1:0]    bx_i,
   input  logic signed [N-1:0]    by_i,
   input  logic signed [N-1:0]    bz_i,
   output vp3_pkg::vp3_ctl_type   ctl_o,
   output logic signed [2*N:0]    dot_o,
   output logic [2*N-1:0]         sq_o,
   output logic [2*N-1:0]         mag_o,
   output logic [2*N-1:0]         rem_o,
   output logic [N:0]             quo_o,
   output logic [N-1:0]           root_o,
   output logic [N+2:0]           srem_o,
   output logic signed [N-1:0]    bx_o,
   output logic signed [N-1:0]    by_o,
   output logic signed [N-1:0]    bz_o
);

   vp3_pkg::vp3_ctl_type   ctl_ff;
   logic signed [2*N:0]    dot_ff;
   logic [2*N-1:0]         sq_ff, mag_ff, rem_ff, rem_in;
   logic [N:0]             quo_ff, quo_in;
   logic [N-1:0]           root_ff, root_in;
   logic [N+2:0]           srem_ff, srem_in;
   logic signed [N-1:0]    bx_ff, by_ff, bz_ff;
   logic [2*N:0]           trial, trial_diff;
   logic                   trial_ge;

   // Restoring division: bring down the next dividend bit and try the divisor.
   always_comb begin
      trial      = {rem_i, mag_i[N-STEP]};
      trial_diff = trial - {1'b0, sq_i};
      trial_ge   = (trial >= {1'b0, sq_i});
      rem_in     = trial_ge ? trial_diff[2*N-1:0] : trial[2*N-1:0];
      quo_in     = {quo_i[N-1:0], trial_ge};
   end

   // Square root, two radicand bits a stage; the last stage only passes it on.
   generate
      if (STEP < N) begin : g_sqrt
         localparam int PAIR_LO = 2 * (N - 1 - STEP);
         logic [N+2:0] shifted, test, diff;
         always_comb begin
            shifted = {srem_i[N:0], sq_i[PAIR_LO+1:PAIR_LO]};
            test    = {1'b0, root_i, 2'b01};
            diff    = shifted - test;
            if (shifted >= test) begin
               srem_in = diff;
               root_in = {root_i[N-2:0], 1'b1};
            end else begin
               srem_in = shifted;
               root_in = {root_i[N-2:0], 1'b0};
            end
         end
      end else begin : g_pass
         always_comb begin
            srem_in = srem_i;
            root_in = root_i;
         end
      end
   endgenerate

   // Stage register; the valid bit alone is cleared by reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff.valid <= 1'b0;
      end else if (en) begin
         ctl_ff.valid <= ctl_i.valid;
      end
      if (en) begin
         ctl_ff.zero <= ctl_i.zero;
         ctl_ff.neg  <= ctl_i.neg;
         dot_ff      <= dot_i;
         sq_ff       <= sq_i;
         mag_ff      <= mag_i;
         rem_ff      <= rem_in;
         quo_ff      <= quo_in;
         root_ff     <= root_in;
         srem_ff     <= srem_in;
         bx_ff       <= bx_i;
         by_ff       <= by_i;
         bz_ff       <= bz_i;
      end
   end

   assign ctl_o  = ctl_ff;
   assign dot_o  = dot_ff;
   assign sq_o   = sq_ff;
   assign mag_o  = mag_ff;
   assign rem_o  = rem_ff;
   assign quo_o  = quo_ff;
   assign root_o = root_ff;
   assign srem_o = srem_ff;
   assign bx_o   = bx_ff;
   assign by_o   = by_ff;
   assign bz_o   = bz_ff;

endmodule

FILE: hw/rtl/vp3_checker.sv
// Port checker for the vector projection unit and its bind statement.
`include "assert_macros.svh"

module vp3_checker #(
   parameter int COMPONENT_BITS = 16
) (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_stall,
   input logic                              rsp_valid,
   input logic                              rsp_stall,
   input logic signed [2*COMPONENT_BITS:0]  rsp_dot_product,
   input logic [COMPONENT_BITS-1:0]         rsp_b_length,
   input logic signed [COMPONENT_BITS:0]    rsp_proj_x,
   input logic signed [COMPONENT_BITS:0]    rsp_proj_y,
   input logic signed [COMPONENT_BITS:0]    rsp_proj_z,
   input logic                              rsp_zero_length
);

   // A held result stays offered.
   `VP3_ASSERT_NEXT(a_rsp_held, rsp_valid && rsp_stall, rsp_valid)

   // The input is stalled exactly when a result is held back.
   `VP3_ASSERT(a_req_stall_match, req_stall == (rsp_valid && rsp_stall))

   // A zero-length b gives zero for every derived field.
   `VP3_ASSERT(a_zero_fields, rsp_valid && rsp_zero_length |-> rsp_proj_x == 0 && rsp_proj_y == 0 && rsp_proj_z == 0 && rsp_b_length == 0 && rsp_dot_product == 0)

   // A non-zero b has a length of at least one.
   `VP3_ASSERT(a_len_nonzero, rsp_valid && !rsp_zero_length |-> rsp_b_length != 0)

   // While an item waits at a stalled input, the held result stays offered.
   `VP3_ASSERT_NEXT(a_no_take_stalled, req_valid && req_stall && rsp_stall, rsp_valid)

endmodule

bind vector_projection_3d_unit vp3_checker #(.COMPONENT_BITS(COMPONENT_BITS)) u_vp3_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_stall       (req_stall),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_dot_product (rsp_dot_product),
   .rsp_b_length    (rsp_b_length),
   .rsp_proj_x      (rsp_proj_x),
   .rsp_proj_y      (rsp_proj_y),
   .rsp_proj_z      (rsp_proj_z),
   .rsp_zero_length (rsp_zero_length)
);
